@@ design/rwca_pkg.sv @@
// ----------------------------------------------------------------------------
// rwca_pkg
// Shared types and constants for the random-walker CA cell update block.
// ----------------------------------------------------------------------------
package rwca_pkg;

    localparam int MAX_GRID = 256;
    localparam int HALO     = 2;
    localparam int ROW_CAP  = MAX_GRID + 2 * HALO;
    localparam int LINES    = 2 * HALO;
    localparam int WIN      = 2 * HALO + 1;
    localparam int CELL_W   = 16;
    localparam int POS_W    = $clog2(ROW_CAP + 1);
    localparam int ADDR_W   = $clog2(ROW_CAP);
    localparam int CNT_W    = 17;
    localparam int TS_W     = 15;
    localparam int GS_W     = 9;
    localparam int DIR_W    = 3;

    localparam logic [0:0] REG_TIME_STEP = 1'b0;
    localparam logic [0:0] REG_GRID_SIZE = 1'b1;

    typedef logic [CELL_W-1:0]                cell_t;
    typedef logic [LINES-1:0][CELL_W-1:0]     line_col_t;
    typedef logic [WIN-1:0][WIN-1:0][CELL_W-1:0] win_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        line_col_t         wr_data;
    } lb_ctrl_t;

endpackage

@@ design/random_walker_ca_cell_update.sv @@
// ----------------------------------------------------------------------------
// random_walker_ca_cell_update
// Streams padded grid cells through a line buffer and 5x5 window and emits
// the next generation of each interior cell with running walker counts.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | in        | in_valid/in_stall   | cell_req, rand_dir, grid_start
//  out     | out       | out_valid/out_stall | new_cell, walker_count,
//          |           |                     | infected_count, last_cell
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One cell per cycle sustained while the output is not stalled; the request
// is registered into stage 1, and the result register loads when stage 1 advances.
// Rate is set by the line buffer read-modify-write (read on accept, write
// back when stage 1 advances, forwarded when the same column is hit again).
// Reset clears position, counts and valids; the line buffer is not cleared.
// A stalled output holds the stage behind it, then the input.
module random_walker_ca_cell_update (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [15:0]                 cell_req,
    input  logic [2:0]                         rand_dir,
    input  logic                               grid_start,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [15:0]                 new_cell,
    output logic [16:0]                        walker_count,
    output logic [16:0]                        infected_count,
    output logic                               last_cell,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [0:0]                         cfg_index,
    input  logic [14:0]                        cfg_data
);
    import rwca_pkg::*;

    logic [TS_W-1:0]  stamp_step_reg;
    logic [GS_W-1:0]  grid_size_reg;
    logic [POS_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [POS_W-1:0] gs, pad, c_cur, r_cur, c_inc, r_inc;
    logic             accept, s1_adv;

    // stage 1
    logic              s1_valid_reg;
    cell_t             s1_cell_reg;
    logic [DIR_W-1:0]  s1_dir_reg;
    logic [ADDR_W-1:0] s1_col_reg;
    logic              s1_emit_reg, s1_last_reg, s1_clear_reg;
    logic              fwd_reg;
    line_col_t         fwd_data_reg;
    line_col_t         mem_q, col_data, wb_data;
    win_t              win_reg, win_next;
    lb_ctrl_t          lb_ctrl;

    logic [CNT_W-1:0]  healthy_reg, infected_reg, h_base, i_base, h_next, i_next;
    logic signed [CELL_W-1:0] rule_val, centre;
    logic [DIR_W-1:0]  dir_fold;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_step_reg <= TS_W'(1);
            grid_size_reg  <= GS_W'(MAX_GRID);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TIME_STEP: stamp_step_reg <= cfg_data[TS_W-1:0];
                REG_GRID_SIZE: grid_size_reg  <= cfg_data[GS_W-1:0];
                default:       ;
            endcase
        end
    end

    // position tracking on the input side
    always_comb
    begin
        if (grid_size_reg < GS_W'(4))
            gs = POS_W'(4);
        else if (grid_size_reg > GS_W'(MAX_GRID))
            gs = POS_W'(MAX_GRID);
        else
            gs = POS_W'(grid_size_reg);
        pad   = gs + POS_W'(2 * HALO);
        c_cur = grid_start ? '0 : col_reg;
        r_cur = grid_start ? '0 : row_reg;
        c_inc = c_cur + POS_W'(1);
        r_inc = r_cur + POS_W'(1);
        if (c_inc >= pad)
        begin
            col_next = '0;
            row_next = (r_inc >= pad) ? '0 : r_inc;
        end
        else
        begin
            col_next = c_inc;
            row_next = r_cur;
        end
    end

    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !out_valid || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    assign col_data = fwd_reg ? fwd_data_reg : mem_q;
    assign wb_data  = {s1_cell_reg, col_data[3], col_data[2], col_data[1]};

    assign lb_ctrl.rd_en   = accept;
    assign lb_ctrl.rd_addr = c_cur[ADDR_W-1:0];
    assign lb_ctrl.wr_en   = s1_adv;
    assign lb_ctrl.wr_addr = s1_col_reg;
    assign lb_ctrl.wr_data = wb_data;

    rwca_line_buf u_line_buf (
        .clk     (clk),
        .ctrl    (lb_ctrl),
        .rd_data (mem_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_adv && (s1_col_reg == c_cur[ADDR_W-1:0]);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
                fwd_reg      <= 1'b0;
            end
        end
    end

    assign dir_fold = DIR_W'({1'b0, 2'(rand_dir + DIR_W'(3))} + DIR_W'(1));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cell_reg  <= cell_req;
            s1_dir_reg   <= dir_fold;
            s1_col_reg   <= c_cur[ADDR_W-1:0];
            fwd_data_reg <= wb_data;
            s1_clear_reg <= (r_cur == '0) && (c_cur == '0);
            s1_emit_reg  <= (r_cur >= POS_W'(2 * HALO)) && (r_cur < pad)
                         && (c_cur >= POS_W'(2 * HALO)) && (c_cur < pad);
            s1_last_reg  <= (r_cur == pad - POS_W'(1)) && (c_cur == pad - POS_W'(1));
        end
    end

    // window shift: new column enters on the right
    always_comb
    begin
        for (int dr = 0; dr < WIN; dr++)
        begin
            for (int k = 0; k < WIN - 1; k++)
                win_next[dr][k] = win_reg[dr][k+1];
            win_next[dr][WIN-1] = (dr < LINES) ? col_data[dr] : s1_cell_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            win_reg <= win_next;
    end

    rwca_rule u_rule (
        .win        (win_next),
        .rnd        (s1_dir_reg),
        .stamp_step (stamp_step_reg),
        .value      (rule_val)
    );

    assign centre = $signed(win_next[2][2]);

    always_comb
    begin
        h_base = s1_clear_reg ? '0 : healthy_reg;
        i_base = s1_clear_reg ? '0 : infected_reg;
        h_next = h_base;
        i_next = i_base;
        if (s1_emit_reg && centre > 16'sd0 && h_base != '1)
            h_next = h_base + CNT_W'(1);
        if (s1_emit_reg && centre < 16'sd0 && i_base != '1)
            i_next = i_base + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            healthy_reg  <= '0;
            infected_reg <= '0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                healthy_reg  <= h_next;
                infected_reg <= i_next;
            end
            if (s1_adv && s1_emit_reg)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            new_cell       <= rule_val;
            walker_count   <= h_next;
            infected_count <= i_next;
            last_cell      <= s1_last_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s1_emit_reg && out_valid)
        else $error("input stalled without a blocked result");

    a_fwd_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("forward flag set with empty stage");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("stalled stage lost its item");
`endif

endmodule

@@ design/rwca_line_buf.sv @@
// ----------------------------------------------------------------------------
// rwca_line_buf
// Line buffer: one column of all stored rows per entry, registered read.
// ----------------------------------------------------------------------------
module rwca_line_buf (
    input  logic               clk,
    input  rwca_pkg::lb_ctrl_t ctrl,
    output rwca_pkg::line_col_t rd_data
);
    import rwca_pkg::*;

    line_col_t mem [ROW_CAP];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data <= mem[ctrl.rd_addr];
        end
    end

endmodule

@@ design/rwca_rule.sv @@
// ----------------------------------------------------------------------------
// rwca_rule
// Next value of the window center: moves, collisions, arrivals, infection.
// ----------------------------------------------------------------------------
module rwca_rule (
    input  rwca_pkg::win_t                  win,
    input  logic [rwca_pkg::DIR_W-1:0]      rnd,
    input  logic [rwca_pkg::TS_W-1:0]       stamp_step,
    output logic signed [rwca_pkg::CELL_W-1:0] value
);
    import rwca_pkg::*;

    logic signed [CELL_W-1:0] x, n, s, e, w, ne, se, sw, nw, nn, ss, ee, ww;
    logic signed [CELL_W-1:0] rnd_c, stamp;
    logic                     sick;
    logic [2:0]               arrivals;

    assign x  = $signed(win[2][2]);
    assign n  = $signed(win[1][2]);
    assign s  = $signed(win[3][2]);
    assign e  = $signed(win[2][3]);
    assign w  = $signed(win[2][1]);
    assign ne = $signed(win[1][3]);
    assign se = $signed(win[3][3]);
    assign sw = $signed(win[3][1]);
    assign nw = $signed(win[1][1]);
    assign nn = $signed(win[0][2]);
    assign ss = $signed(win[4][2]);
    assign ee = $signed(win[2][4]);
    assign ww = $signed(win[2][0]);

    assign rnd_c = $signed({{(CELL_W-DIR_W){1'b0}}, rnd});
    assign stamp = -$signed({1'b0, stamp_step});
    assign sick  = n[CELL_W-1] | e[CELL_W-1] | s[CELL_W-1] | w[CELL_W-1]
                 | ne[CELL_W-1] | se[CELL_W-1] | sw[CELL_W-1] | nw[CELL_W-1];
    assign arrivals = 3'({2'b0, n == 16'sd3} + {2'b0, e == 16'sd4}
                       + {2'b0, s == 16'sd1} + {2'b0, w == 16'sd2});

    always_comb
    begin
        if (x == 16'sd0)
            value = (arrivals == 3'd1) ? rnd_c : '0;
        else if (x == 16'sd1 && n == 16'sd0)
            value = (ne == 16'sd4 || nw == 16'sd2 || nn == 16'sd3) ? rnd_c : '0;
        else if (x == 16'sd2 && e == 16'sd0)
            value = (ne == 16'sd3 || se == 16'sd1 || ee == 16'sd4) ? rnd_c : '0;
        else if (x == 16'sd3 && s == 16'sd0)
            value = (se == 16'sd4 || sw == 16'sd2 || ss == 16'sd1) ? rnd_c : '0;
        else if (x == 16'sd4 && w == 16'sd0)
            value = (sw == 16'sd1 || nw == 16'sd3 || ww == 16'sd2) ? rnd_c : '0;
        else if (x > 16'sd0 && sick)
            value = stamp;
        else if (x >= 16'sd1 && x <= 16'sd4)
            value = rnd_c;
        else
            value = x;
    end

endmodule
